### rtl/bmp_raster_pixel_decoder_top_assert.svh
// Assertion macros for the BMP raster pixel decoder top level.
// Plain SystemVerilog concurrent assertions; no other dependencies.
`ifndef BMP_RASTER_PIXEL_DECODER_TOP_ASSERT_SVH
`define BMP_RASTER_PIXEL_DECODER_TOP_ASSERT_SVH

// Check that post holds in the same cycle as pre.
`define BMP_RPD_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Check that post holds in the cycle after pre.
`define BMP_RPD_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

### rtl/bmp_rpd_pkg.sv
// Shared types and constants of the BMP raster pixel decoder.
// Used by every module of the block; depends on nothing.
package bmp_rpd_pkg;

   localparam int CSR_AW      = 5;
   localparam int COL_W       = 13;
   localparam int ROW_W       = 13;
   localparam int ROW_BYTES_W = 15;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   localparam logic OP_PALETTE_WRITE = 1'b0;
   localparam logic OP_PIXEL_BYTE    = 1'b1;

   typedef enum logic [2:0] {
      REG_PIXEL_FORMAT = 3'd0,
      REG_IMAGE_WIDTH  = 3'd1,
      REG_IMAGE_HEIGHT = 3'd2,
      REG_MIRROR_X     = 3'd3,
      REG_TOP_DOWN     = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      FMT_BPP1  = 3'd0,
      FMT_BPP4  = 3'd1,
      FMT_BPP8  = 3'd2,
      FMT_BPP16 = 3'd3,
      FMT_BPP24 = 3'd4,
      FMT_BPP32 = 3'd5
   } fmt_type;

   localparam logic [2:0] FMT_RESET = 3'd5;

   typedef enum logic [1:0] {
      JOB_PAL_WR = 2'd0,
      JOB_LOOKUP = 2'd1,
      JOB_DIRECT = 2'd2
   } job_kind_type;

   // 5-bit channel scaled by 255/31, rounded down
   localparam logic [7:0] SCALE5 [32] = '{
      8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
      8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
      8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
      8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
   };

   typedef struct packed {
      logic        op;
      logic [7:0]  palette_slot;
      logic [23:0] palette_bgr;
      logic [7:0]  data_byte;
   } req_word_type;

   typedef struct packed {
      logic [11:0] dest_col;
      logic [11:0] dest_row;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        last_of_byte;
   } rsp_word_type;

   typedef struct packed {
      fmt_type                  fmt;
      logic [COL_W-1:0]         w_eff;
      logic [ROW_W-1:0]         h_eff;
      logic                     mirror_x;
      logic                     top_down;
      logic [ROW_BYTES_W-1:0]   row_pitch;
   } cfg_type;

   // one classified word; data holds the pixel byte or the palette slot,
   // color holds the palette entry or a finished direct pixel as {r, g, b}
   typedef struct packed {
      job_kind_type kind;
      fmt_type      fmt;
      logic         mirror_x;
      logic [3:0]   count;
      logic [11:0]  base_col;
      logic [11:0]  row;
      logic [7:0]   data;
      logic [23:0]  color;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic issue;
      logic pal_wr;
      logic pop;
   } back_stat_type;

endpackage

### rtl/bmp_rpd_csr.sv
// Configuration registers of the BMP raster pixel decoder on an APB-style port.
// Derives effective width, height, format and row size; uses bmp_rpd_pkg.
module bmp_rpd_csr
   import bmp_rpd_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg,
   output logic              restart
);

   logic [2:0]       fmt_raw_ff;
   logic [COL_W-1:0] width_ff;
   logic [ROW_W-1:0] height_ff;
   logic             mirror_ff;
   logic             top_down_ff;

   logic [2:0]  reg_idx;
   logic        wr_en;
   logic [18:0] row_bits;
   logic [18:0] row_bits_up;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign restart    = wr_en && (reg_idx <= REG_TOP_DOWN);

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_raw_ff  <= FMT_RESET;
         width_ff    <= 13'd1;
         height_ff   <= 13'd1;
         mirror_ff   <= 1'b0;
         top_down_ff <= 1'b0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_PIXEL_FORMAT: fmt_raw_ff  <= csr_pwdata[2:0];
            REG_IMAGE_WIDTH:  width_ff    <= csr_pwdata[COL_W-1:0];
            REG_IMAGE_HEIGHT: height_ff   <= csr_pwdata[ROW_W-1:0];
            REG_MIRROR_X:     mirror_ff   <= csr_pwdata[0];
            REG_TOP_DOWN:     top_down_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PIXEL_FORMAT: csr_prdata = {29'd0, fmt_raw_ff};
         REG_IMAGE_WIDTH:  csr_prdata = {{(32-COL_W){1'b0}}, width_ff};
         REG_IMAGE_HEIGHT: csr_prdata = {{(32-ROW_W){1'b0}}, height_ff};
         REG_MIRROR_X:     csr_prdata = {31'd0, mirror_ff};
         REG_TOP_DOWN:     csr_prdata = {31'd0, top_down_ff};
         default:          csr_prdata = '0;
      endcase
   end

   always_comb begin
      // unknown format codes act as 32 bpp
      priority if (fmt_raw_ff > FMT_RESET) cfg.fmt = FMT_BPP32;
      else                                 cfg.fmt = fmt_type'(fmt_raw_ff);

      priority if (width_ff == '0)                    cfg.w_eff = 13'd1;
      else if (32'(width_ff) > 32'(MAX_WIDTH))        cfg.w_eff = COL_W'(MAX_WIDTH);
      else                                            cfg.w_eff = width_ff;

      priority if (height_ff == '0)                   cfg.h_eff = 13'd1;
      else if (32'(height_ff) > 32'(MAX_HEIGHT))      cfg.h_eff = ROW_W'(MAX_HEIGHT);
      else                                            cfg.h_eff = height_ff;

      cfg.mirror_x = mirror_ff;
      cfg.top_down = top_down_ff;

      unique case (cfg.fmt)
         FMT_BPP1:  row_bits = {6'd0, cfg.w_eff};
         FMT_BPP4:  row_bits = {4'd0, cfg.w_eff, 2'd0};
         FMT_BPP8:  row_bits = {3'd0, cfg.w_eff, 3'd0};
         FMT_BPP16: row_bits = {2'd0, cfg.w_eff, 4'd0};
         FMT_BPP24: row_bits = {2'd0, cfg.w_eff, 4'd0} + {3'd0, cfg.w_eff, 3'd0};
         default:   row_bits = {1'b0, cfg.w_eff, 5'd0};
      endcase
      // round up to whole 32-bit words, count in bytes
      row_bits_up   = row_bits + 19'd31;
      cfg.row_pitch = {row_bits_up[17:5], 2'd0};
   end

endmodule

### rtl/bmp_rpd_front.sv
// Front end of the BMP raster pixel decoder: accepts words, tracks row,
// column and byte position, and queues classified jobs; uses bmp_rpd_pkg.
module bmp_rpd_front
   import bmp_rpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         restart,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   input  logic         q_full,
   output logic         q_push,
   output job_type      q_job
);

   logic [ROW_BYTES_W-1:0] rbc_ff, rbc_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [1:0]             phase_ff, phase_in;
   logic [23:0]            partial_ff, partial_in;

   logic                   accept;
   logic                   is_data;
   logic                   is_paletted;
   logic                   has_room;
   logic [COL_W-1:0]       remaining;
   logic [3:0]             ppb;
   logic [3:0]             pal_n;
   logic [2:0]             nbytes;
   logic                   done;
   logic [23:0]            part_new;
   logic [7:0]             c0, c1, c2;
   logic [23:0]            direct_color;
   logic                   row_end;
   logic [ROW_W-1:0]       row_next;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign is_data   = (req_data.op == OP_PIXEL_BYTE);

   always_comb begin
      is_paletted = (cfg.fmt == FMT_BPP1) || (cfg.fmt == FMT_BPP4) || (cfg.fmt == FMT_BPP8);
      has_room    = col_ff < cfg.w_eff;
      remaining   = cfg.w_eff - col_ff;

      unique case (cfg.fmt)
         FMT_BPP1: ppb = 4'd8;
         FMT_BPP4: ppb = 4'd2;
         default:  ppb = 4'd1;
      endcase
      // stop at the row width on a partial last byte
      pal_n = (remaining < {{(COL_W-4){1'b0}}, ppb}) ? remaining[3:0] : ppb;

      unique case (cfg.fmt)
         FMT_BPP16: nbytes = 3'd2;
         FMT_BPP24: nbytes = 3'd3;
         default:   nbytes = 3'd4;
      endcase

      unique case (phase_ff)
         2'd0:    part_new = partial_ff | {16'd0, req_data.data_byte};
         2'd1:    part_new = partial_ff | {8'd0, req_data.data_byte, 8'd0};
         2'd2:    part_new = partial_ff | {req_data.data_byte, 16'd0};
         default: part_new = partial_ff;
      endcase
      done = ({1'b0, phase_ff} + 3'd1) >= nbytes;

      c0 = part_new[7:0];
      c1 = part_new[15:8];
      c2 = part_new[23:16];
      if (cfg.fmt == FMT_BPP16) begin
         direct_color = {SCALE5[c1[6:2]], SCALE5[{c1[1:0], c0[7:5]}], SCALE5[c0[4:0]]};
      end else begin
         direct_color = {c2, c1, c0};
      end
   end

   always_comb begin
      q_job.kind     = !is_data ? JOB_PAL_WR : (is_paletted ? JOB_LOOKUP : JOB_DIRECT);
      q_job.fmt      = cfg.fmt;
      q_job.mirror_x = cfg.mirror_x;
      q_job.count    = is_paletted ? pal_n : 4'd1;
      q_job.base_col = cfg.mirror_x ? 12'(cfg.w_eff - 13'd1 - col_ff) : col_ff[11:0];
      q_job.row      = cfg.top_down ? row_ff[11:0] : 12'(cfg.h_eff - 13'd1 - row_ff);
      q_job.data     = is_data ? req_data.data_byte : req_data.palette_slot;
      q_job.color    = is_data ? direct_color : req_data.palette_bgr;
      q_push         = accept && (!is_data || (has_room && (is_paletted || done)));
   end

   always_comb begin
      rbc_in     = rbc_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      phase_in   = phase_ff;
      partial_in = partial_ff;
      row_end    = ({1'b0, rbc_ff} + 16'd1) >= {1'b0, cfg.row_pitch};
      row_next   = row_ff + 13'd1;

      if (restart) begin
         rbc_in     = '0;
         col_in     = '0;
         row_in     = '0;
         phase_in   = '0;
         partial_in = '0;
      end else if (accept && is_data) begin
         if (has_room) begin
            if (is_paletted) begin
               col_in = col_ff + COL_W'(pal_n);
            end else if (done) begin
               col_in     = col_ff + 13'd1;
               phase_in   = '0;
               partial_in = '0;
            end else begin
               phase_in   = phase_ff + 2'd1;
               partial_in = part_new;
            end
         end
         // skip row padding, wrap after the last row
         if (row_end) begin
            rbc_in     = '0;
            col_in     = '0;
            phase_in   = '0;
            partial_in = '0;
            row_in     = (row_next >= cfg.h_eff) ? '0 : row_next;
         end else begin
            rbc_in = rbc_ff + 15'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rbc_ff     <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         phase_ff   <= '0;
         partial_ff <= '0;
      end else begin
         rbc_ff     <= rbc_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         phase_ff   <= phase_in;
         partial_ff <= partial_in;
      end
   end

endmodule

### rtl/bmp_rpd_queue.sv
// Short job queue between the front and back ends of the pixel decoder.
// Holds classified jobs in order; uses bmp_rpd_pkg.
module bmp_rpd_queue
   import bmp_rpd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  job_type        push_job,
   input  logic           pop,
   output job_type        head_job,
   output queue_stat_type stat
);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff;

   assign head_job   = entry_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + (QUEUE_AW+1)'(1);
            2'b01:   count_ff <= count_ff - (QUEUE_AW+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

### rtl/bmp_rpd_back.sv
// Back end of the pixel decoder: palette memory, per-pixel sequencer and
// output register. Takes jobs from bmp_rpd_queue; uses bmp_rpd_pkg.
module bmp_rpd_back
   import bmp_rpd_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  job_type       head_job,
   output back_stat_type stat,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output rsp_word_type  rsp_data
);

   localparam int PAL_AW = $clog2(PALETTE_DEPTH);

   logic [23:0]              pal_mem [PALETTE_DEPTH];
   logic [PALETTE_DEPTH-1:0] pal_vld_ff;
   logic [2:0]               pix_ff, pix_in;

   logic                     rsp_valid_ff;
   logic [11:0]              col_ff;
   logic [11:0]              row_ff;
   logic                     last_ff;
   logic                     src_pal_ff;
   logic                     hit_ff;
   logic [23:0]              color_ff;
   logic [23:0]              pal_rd_ff;

   logic [7:0]               idx;
   logic                     idx_ok;
   logic                     slot_ok;
   logic [PAL_AW-1:0]        rd_addr;
   logic [PAL_AW-1:0]        wr_addr;
   logic                     is_wr;
   logic                     is_pix;
   logic                     out_free;
   logic                     last_pix;
   logic                     pix_done;
   logic [11:0]              col;
   logic [23:0]              color;

   always_comb begin
      // most significant pixel first within the byte
      unique case (head_job.fmt)
         FMT_BPP1: idx = {7'd0, head_job.data[3'd7 - pix_ff]};
         FMT_BPP4: idx = pix_ff[0] ? {4'd0, head_job.data[3:0]} : {4'd0, head_job.data[7:4]};
         default:  idx = head_job.data;
      endcase
      idx_ok   = {1'b0, idx} < 9'(PALETTE_DEPTH);
      slot_ok  = {1'b0, head_job.data} < 9'(PALETTE_DEPTH);
      rd_addr  = idx[PAL_AW-1:0];
      wr_addr  = head_job.data[PAL_AW-1:0];

      is_wr    = head_valid && (head_job.kind == JOB_PAL_WR);
      is_pix   = head_valid && (head_job.kind != JOB_PAL_WR);
      out_free = !rsp_valid_ff || !rsp_stall;
      last_pix = ({1'b0, pix_ff} + 4'd1) == head_job.count;
      pix_done = (head_job.kind == JOB_DIRECT) || last_pix;

      stat.pal_wr = is_wr && slot_ok;
      stat.issue  = is_pix && out_free;
      stat.pop    = is_wr || (stat.issue && pix_done);

      col = head_job.mirror_x ? (head_job.base_col - {9'd0, pix_ff})
                              : (head_job.base_col + {9'd0, pix_ff});

      pix_in = pix_ff;
      if (stat.issue) begin
         pix_in = pix_done ? 3'd0 : (pix_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (stat.pal_wr) begin
         pal_mem[wr_addr] <= head_job.color;
      end
      if (stat.issue) begin
         pal_rd_ff <= pal_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_vld_ff   <= '0;
         pix_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (stat.pal_wr) pal_vld_ff[wr_addr] <= 1'b1;
         pix_ff       <= pix_in;
         rsp_valid_ff <= stat.issue || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (stat.issue) begin
         col_ff     <= col;
         row_ff     <= head_job.row;
         last_ff    <= pix_done;
         src_pal_ff <= (head_job.kind == JOB_LOOKUP);
         hit_ff     <= idx_ok && pal_vld_ff[rd_addr];
         color_ff   <= head_job.color;
      end
   end

   // an entry never written reads as black
   assign color = src_pal_ff ? (hit_ff ? pal_rd_ff : 24'd0) : color_ff;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.dest_col     = col_ff;
   assign rsp_data.dest_row     = row_ff;
   assign rsp_data.red          = color[23:16];
   assign rsp_data.green        = color[15:8];
   assign rsp_data.blue         = color[7:0];
   assign rsp_data.last_of_byte = last_ff;

endmodule

### rtl/bmp_raster_pixel_decoder_top.sv
// Top level of the BMP raster pixel decoder: registers, front end, job queue
// and back end. Uses bmp_rpd_pkg and the assertion macros header.
//
// Usage: load palette entries and pixel-array bytes (padding included) as
// words on the req_ channel; RGB pixels with destination column and row leave
// on the rsp_ channel, last_of_byte marking the final pixel of each byte.
// Registers are written over the csr_ port while the block is idle; any
// register write restarts the frame counters and keeps the palette.
// Path: with the queue empty, an accepted byte is written into the job queue,
// issued from its head and held in the output register that drives rsp_.
// Input rate: one word per cycle through a four-entry queue while it is not full.
// Output rate: one pixel per cycle while rsp_ is not stalled, set by the single
// palette read port, so a 1 bpp byte yields up to 8 pixels, a 4 bpp byte 2, and
// every other byte at most 1. A stalled rsp_ word holds; the queue keeps
// taking words until it fills, then req_stall rises.
// Reset: registers return to their defaults, counters clear, and every palette
// entry reads as black until written; no clearing pass is needed.
`include "bmp_raster_pixel_decoder_top_assert.svh"

module bmp_raster_pixel_decoder_top
   import bmp_rpd_pkg::*;
#(
   parameter int MAX_WIDTH     = 4096,
   parameter int MAX_HEIGHT    = 4096,
   parameter int PALETTE_DEPTH = 256
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_word_type      req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_word_type      rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   cfg_type        cfg;
   logic           restart;
   logic           q_push;
   job_type        q_job;
   job_type        head_job;
   queue_stat_type q_stat;
   back_stat_type  bk_stat;

   bmp_rpd_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .restart     (restart)
   );

   bmp_rpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .restart   (restart),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_stat.full),
      .q_push    (q_push),
      .q_job     (q_job)
   );

   bmp_rpd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .pop      (bk_stat.pop),
      .head_job (head_job),
      .stat     (q_stat)
   );

   bmp_rpd_back #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!q_stat.empty),
      .head_job   (head_job),
      .stat       (bk_stat),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   `BMP_RPD_ASSERT_NOW(a_push_room, clock, reset, q_push, !q_stat.full, "push into full queue")
   `BMP_RPD_ASSERT_NOW(a_pop_data, clock, reset, bk_stat.pop, !q_stat.empty, "pop from empty queue")
   `BMP_RPD_ASSERT_NOW(a_wr_no_issue, clock, reset, bk_stat.pal_wr, !bk_stat.issue, "palette write with pixel issue")
   `BMP_RPD_ASSERT_NEXT(a_issue_shows, clock, reset, bk_stat.issue, rsp_valid, "issued pixel not presented")

endmodule
